// ===== src/gbn_pkg.sv =====
// Shared types, constants and codes for the Go-Back-N sender.
`timescale 1ns / 1ps

package gbn_pkg;

    // Retransmit buffer depth; must stay a power of two (index is seq modulo depth)
    localparam int BUF_DEPTH     = 32;
    localparam int BUF_IDX_W     = $clog2(BUF_DEPTH);

    localparam int SEQ_W         = 31;
    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int BYTE_IDX_W    = $clog2(PAYLOAD_BYTES);
    localparam int WIN_W         = 6;
    localparam int MAX_WIN       = 32;
    localparam int TMO_W         = 16;

    // Configuration port
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = CFG_IDX_W'(1);

    // Request codes
    localparam logic [1:0] REQ_MSG  = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Result kinds
    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_REFUSE = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        pkt_word0;
        logic [63:0]        pkt_word1;
        logic [31:0]        pkt_word2;
        logic signed [31:0] pkt_seq;
        logic signed [31:0] ack_num;
        logic signed [31:0] pkt_checksum;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [SEQ_W-1:0]   out_seq;
        logic [63:0]        out_word0;
        logic [63:0]        out_word1;
        logic [31:0]        out_word2;
        logic signed [31:0] out_checksum;
        logic               last;
    } t_out_item;

    // One retransmit buffer entry: payload plus its signed byte sum
    typedef struct packed {
        logic [63:0] word0;
        logic [63:0] word1;
        logic [31:0] word2;
        logic [31:0] bsum;
    } t_buf_entry;

    typedef struct packed {
        logic                 en;
        logic [BUF_IDX_W-1:0] addr;
        t_buf_entry           entry;
    } t_buf_wr;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_ADD_DEC,
        ALU_ACC_BYTE
    } t_alu_op;

    typedef struct packed {
        t_alu_op               op;
        logic [31:0]           a;
        logic [31:0]           b;
        logic [PAYLOAD_W-1:0]  payload;
        logic [BYTE_IDX_W-1:0] bidx;
    } t_alu_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_CK_SEQ,
        S_CK_ACK,
        S_ACK_CHK,
        S_MSG,
        S_RD,
        S_CSUM,
        S_OUT
    } t_state;

endpackage

// ===== src/gbn_alu.sv =====
// Shared 32-bit adder: plain add, add minus one, and signed payload byte accumulate.
`timescale 1ns / 1ps

module gbn_alu import gbn_pkg::*; (
    input  t_alu_ctl    i_ctl,
    output logic [31:0] o_result,
    output logic        o_byte_zero
);

    logic [7:0]  byte_sel;
    logic [31:0] byte_ext;

    // Byte pick and sign extension
    always_comb begin
        byte_sel    = i_ctl.payload[{i_ctl.bidx, 3'b000} +: 8];
        byte_ext    = {{24{byte_sel[7]}}, byte_sel};
        o_byte_zero = (byte_sel == 8'd0);
    end

    // Adder, operand chosen by op
    always_comb begin
        case (i_ctl.op)
            ALU_ADD:      o_result = i_ctl.a + i_ctl.b;
            ALU_ADD_DEC:  o_result = i_ctl.a + i_ctl.b - 32'd1;
            ALU_ACC_BYTE: o_result = i_ctl.a + byte_ext;
            default:      o_result = i_ctl.a + i_ctl.b;
        endcase
    end

endmodule

// ===== src/gbn_buf.sv =====
// Retransmit buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module gbn_buf import gbn_pkg::*; (
    input  logic                 i_clk,
    input  t_buf_wr              i_wr,
    input  logic                 i_rd_en,
    input  logic [BUF_IDX_W-1:0] i_rd_addr,
    output t_buf_entry           o_rd_data
);

    t_buf_entry r_mem [BUF_DEPTH];
    t_buf_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/go_back_n_sender.sv =====
// Go-Back-N ARQ sender: top level with sequencer, window state and retransmit timer.
//
// Input channel (i_in_valid / o_in_ready, item i_in): req_type 0 is a message to
// number, buffer and send if inside the window; 1 is an arriving ack; 2 is a tick.
// Output channel (o_out_valid / i_out_ready, item o_out): one item per sent packet
// or refused message; last marks the final item caused by an input.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 window size,
// index 1 timeout in ticks; write only while idle.
// One item is in work at a time; o_in_ready is high only when idle.
// Per item: after the accepting cycle, a message or ack runs the shared adder one
// payload byte per cycle up to the first zero byte or the last byte, then a buffer
// write (message) or seq add, ack add and check (ack). A tick without expiry goes
// straight back to idle. Each emitted packet then passes buffer read, checksum add
// and output, held while i_out_ready is low; a refusal goes straight to output.
// A stalled receiver simply holds the sequencer in its output state.
// Reset (synchronous, active low): base and next sequence 1, timer idle, window 8,
// timeout 14. No clearing pass; buffer entries are read only after being written.
`timescale 1ns / 1ps

module go_back_n_sender import gbn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Control state
    t_state             r_state, n_state;
    logic [SEQ_W-1:0]   r_base, n_base;
    logic [SEQ_W-1:0]   r_next, n_next;
    logic [TMO_W-1:0]   r_timer_left, n_timer_left;
    logic               r_timer_on, n_timer_on;
    logic [WIN_W-1:0]   r_win_cfg, n_win_cfg;
    logic [TMO_W-1:0]   r_tmo, n_tmo;
    logic               r_out_valid, n_out_valid;

    // Working registers
    t_in_item              r_req, n_req;
    logic [31:0]           r_acc, n_acc;
    logic [BYTE_IDX_W-1:0] r_bidx, n_bidx;
    logic [31:0]           r_emit_seq, n_emit_seq;
    logic [31:0]           r_emit_stop, n_emit_stop;
    t_out_item             r_out, n_out;

    // Unit connections
    t_alu_ctl             alu_ctl;
    logic [31:0]          alu_result;
    logic                 alu_byte_zero;
    t_buf_wr              buf_wr;
    logic                 buf_rd_en;
    logic [BUF_IDX_W-1:0] buf_rd_addr;
    t_buf_entry           buf_rd_data;

    // Derived values
    logic                 in_acc, out_acc, cfg_acc;
    logic [WIN_W-1:0]     eff_win;
    logic [31:0]          win_x, base_x, next_x, base_win, tick_stop;
    logic [SEQ_W-1:0]     outstanding;
    logic                 buf_full;
    logic [SEQ_W-1:0]     ack_seq, new_base;
    logic [31:0]          ack_stop_raw, ack_stop;
    logic                 ack_ok;
    logic                 sum_done;
    logic                 tick_expire;

    gbn_alu u_alu (
        .i_ctl       (alu_ctl),
        .o_result    (alu_result),
        .o_byte_zero (alu_byte_zero)
    );

    gbn_buf u_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_en   (buf_rd_en),
        .i_rd_addr (buf_rd_addr),
        .o_rd_data (buf_rd_data)
    );

    // Handshakes
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Window arithmetic and checks
    always_comb begin
        if (r_win_cfg == '0) begin
            eff_win = WIN_W'(1);
        end else if (r_win_cfg > WIN_W'(MAX_WIN)) begin
            eff_win = WIN_W'(MAX_WIN);
        end else begin
            eff_win = r_win_cfg;
        end
        win_x       = 32'(eff_win);
        base_x      = {1'b0, r_base};
        next_x      = {1'b0, r_next};
        base_win    = base_x + win_x;
        tick_stop   = (base_win < next_x) ? base_win : next_x;
        outstanding = r_next - r_base;
        buf_full    = (outstanding >= SEQ_W'(BUF_DEPTH)) || (r_next == '1);

        ack_seq      = r_req.ack_num[SEQ_W-1:0];
        new_base     = ack_seq + SEQ_W'(1);
        ack_stop_raw = {1'b0, new_base} + win_x;
        ack_stop     = (ack_stop_raw < next_x) ? ack_stop_raw : next_x;
        ack_ok       = (r_acc == $unsigned(r_req.pkt_checksum)) && !r_req.ack_num[31]
                       && (ack_seq >= r_base) && (ack_seq < r_next);

        sum_done    = alu_byte_zero || (r_bidx == BYTE_IDX_W'(PAYLOAD_BYTES - 1));
        tick_expire = r_timer_on && (r_timer_left <= TMO_W'(1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.req_type)
                        REQ_MSG:  n_state = buf_full ? S_OUT : S_SUM;
                        REQ_ACK:  n_state = S_SUM;
                        REQ_TICK: n_state = (tick_expire && (r_next != r_base)) ? S_RD
                                                                                : S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SUM: begin
                if (sum_done) begin
                    n_state = (r_req.req_type == REQ_MSG) ? S_MSG : S_CK_SEQ;
                end
            end
            S_CK_SEQ:  n_state = S_CK_ACK;
            S_CK_ACK:  n_state = S_ACK_CHK;
            S_ACK_CHK: n_state = (ack_ok && (base_win < ack_stop)) ? S_RD : S_IDLE;
            S_MSG:     n_state = (next_x < base_win) ? S_RD : S_IDLE;
            S_RD:      n_state = S_CSUM;
            S_CSUM:    n_state = S_OUT;
            S_OUT: begin
                if (out_acc) begin
                    n_state = r_out.last ? S_IDLE : S_RD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: intake, adder operands, buffer ports
    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        alu_ctl.op      = ALU_ADD;
        alu_ctl.a       = r_acc;
        alu_ctl.b       = '0;
        alu_ctl.payload = {r_req.pkt_word2, r_req.pkt_word1, r_req.pkt_word0};
        alu_ctl.bidx    = r_bidx;
        buf_rd_en       = (r_state == S_RD);
        buf_rd_addr     = r_emit_seq[BUF_IDX_W-1:0];
        buf_wr.en       = (r_state == S_MSG);
        buf_wr.addr     = r_next[BUF_IDX_W-1:0];
        buf_wr.entry    = '{word0: r_req.pkt_word0, word1: r_req.pkt_word1,
                            word2: r_req.pkt_word2, bsum: r_acc};
        case (r_state)
            S_SUM:    alu_ctl.op = ALU_ACC_BYTE;
            S_CK_SEQ: alu_ctl.b  = $unsigned(r_req.pkt_seq);
            S_CK_ACK: alu_ctl.b  = $unsigned(r_req.ack_num);
            S_CSUM: begin
                alu_ctl.op = ALU_ADD_DEC;
                alu_ctl.a  = {1'b0, r_emit_seq[SEQ_W-1:0]};
                alu_ctl.b  = buf_rd_data.bsum;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_base       = r_base;
        n_next       = r_next;
        n_timer_left = r_timer_left;
        n_timer_on   = r_timer_on;
        n_win_cfg    = r_win_cfg;
        n_tmo        = r_tmo;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_acc        = r_acc;
        n_bidx       = r_bidx;
        n_emit_seq   = r_emit_seq;
        n_emit_stop  = r_emit_stop;
        n_out        = r_out;

        // Register writes
        if (cfg_acc) begin
            case (i_cfg_index)
                CFG_WINDOW_SIZE:   n_win_cfg = i_cfg_data[WIN_W-1:0];
                CFG_TIMEOUT_TICKS: n_tmo     = i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req  = i_in;
                    n_acc  = '0;
                    n_bidx = '0;
                    case (i_in.req_type)
                        REQ_MSG: begin
                            if (buf_full) begin
                                n_out             = '0;
                                n_out.result_kind = KIND_REFUSE;
                                n_out.last        = 1'b1;
                                n_out_valid       = 1'b1;
                            end
                        end
                        REQ_TICK: begin
                            // Expiry resends the window and restarts the timer
                            if (tick_expire) begin
                                n_timer_left = r_tmo;
                                n_emit_seq   = base_x;
                                n_emit_stop  = tick_stop;
                            end else if (r_timer_on) begin
                                n_timer_left = r_timer_left - TMO_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SUM: begin
                if (!alu_byte_zero) begin
                    n_acc = alu_result;
                end
                if (!sum_done) begin
                    n_bidx = r_bidx + BYTE_IDX_W'(1);
                end
            end
            S_CK_SEQ, S_CK_ACK: n_acc = alu_result;
            S_ACK_CHK: begin
                // Good ack: slide the window, send what newly fits, restart timer
                if (ack_ok) begin
                    n_base       = new_base;
                    n_emit_seq   = base_win;
                    n_emit_stop  = ack_stop;
                    n_timer_on   = 1'b1;
                    n_timer_left = r_tmo;
                end
            end
            S_MSG: begin
                if ((r_base == r_next) && !r_timer_on) begin
                    n_timer_on   = 1'b1;
                    n_timer_left = r_tmo;
                end
                n_emit_seq  = next_x;
                n_emit_stop = next_x + 32'd1;
                n_next      = r_next + SEQ_W'(1);
            end
            S_CSUM: begin
                n_out.result_kind  = KIND_SEND;
                n_out.out_seq      = r_emit_seq[SEQ_W-1:0];
                n_out.out_word0    = buf_rd_data.word0;
                n_out.out_word1    = buf_rd_data.word1;
                n_out.out_word2    = buf_rd_data.word2;
                n_out.out_checksum = $signed(alu_result);
                n_out.last         = ((r_emit_seq + 32'd1) == r_emit_stop);
                n_out_valid        = 1'b1;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    if (!r_out.last) begin
                        n_emit_seq = r_emit_seq + 32'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base       <= SEQ_W'(1);
            r_next       <= SEQ_W'(1);
            r_timer_left <= '0;
            r_timer_on   <= 1'b0;
            r_win_cfg    <= WIN_W'(8);
            r_tmo        <= TMO_W'(14);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_base       <= n_base;
            r_next       <= n_next;
            r_timer_left <= n_timer_left;
            r_timer_on   <= n_timer_on;
            r_win_cfg    <= n_win_cfg;
            r_tmo        <= n_tmo;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_acc       <= n_acc;
        r_bidx      <= n_bidx;
        r_emit_seq  <= n_emit_seq;
        r_emit_stop <= n_emit_stop;
        r_out       <= n_out;
    end

    // Window never inverts
    a_base_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= r_next)
        else $error("base sequence passed next sequence");

    // Buffer never overfills
    a_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next - r_base) <= SEQ_W'(BUF_DEPTH))
        else $error("more packets outstanding than buffer entries");

    // Intake only with no result pending
    a_ready_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    // A refusal is always the only result
    a_refuse_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.result_kind == KIND_REFUSE)) |-> o_out.last)
        else $error("refusal without last");

    // Burst continues with the next buffer read
    a_burst_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last) |=> (r_state == S_RD))
        else $error("burst did not continue");

endmodule

// ===== test/tb_go_back_n_sender.sv =====
// Self-checking testbench for the Go-Back-N sender: directed and random traffic.
`timescale 1ns / 1ps

module tb_go_back_n_sender;
    import gbn_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 40;     // idle margin beyond the longest item that gives no result
    localparam int          LONG_STALL    = 400;
    localparam int          LOOK          = 0;      // look-ahead copy used to build stimulus
    localparam int          CHK           = 1;      // copy advanced on accepted items
    localparam int unsigned SEQ_CAP       = 32'h7FFF_FFFF;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    // DUT connections
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Sender state, one copy per role
    int unsigned     m_base [2];
    int unsigned     m_next [2];
    int unsigned     m_tleft [2];
    bit              m_ton [2];
    logic [5:0]      m_win [2];
    logic [15:0]     m_tmo [2];
    logic [63:0]     m_lo [2][BUF_DEPTH];
    logic [63:0]     m_mid [2][BUF_DEPTH];
    logic [31:0]     m_hi [2][BUF_DEPTH];
    logic [31:0]     m_bsum [2][BUF_DEPTH];

    t_out_item       step_res [$];     // results caused by the last item stepped
    t_out_item       due_out_q [$];    // packets/refusals still owed by the DUT
    t_in_item        req_backlog [$];  // items waiting to be offered
    t_out_item       got_want;

    int              n_queued, n_items, n_results, n_refused, max_burst, n_cfg, n_err;
    int              n_cycles;
    int              stall_left, stalls_asked, stalls_done;
    bit              idle_on = 1'b1;

    go_back_n_sender dut (.*);

    always #5 i_clk = ~i_clk;

    // Signed byte sum up to the first zero byte
    function automatic logic [31:0] payload_sum(logic [63:0] w0, logic [63:0] w1,
                                                logic [31:0] w2);
        logic [159:0] p;
        logic [31:0]  acc;
        logic [7:0]   b;
        p   = {w2, w1, w0};
        acc = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            b = p[i*8 +: 8];
            if (b == 8'h00) break;
            acc = acc + {{24{b[7]}}, b};
        end
        return acc;
    endfunction

    function automatic void restart_timer(int m);
        m_ton[m]   = 1'b1;
        m_tleft[m] = m_tmo[m];
    endfunction

    function automatic t_out_item sent_packet(int m, int unsigned seq);
        t_out_item   pk;
        int unsigned slot;
        slot             = seq % BUF_DEPTH;
        pk               = '0;
        pk.result_kind   = KIND_SEND;
        pk.out_seq       = SEQ_W'(seq);
        pk.out_word0     = m_lo[m][slot];
        pk.out_word1     = m_mid[m][slot];
        pk.out_word2     = m_hi[m][slot];
        pk.out_checksum  = seq + 32'hFFFF_FFFF + m_bsum[m][slot];
        return pk;
    endfunction

    function automatic void apply_cfg(int m, logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_WINDOW_SIZE) m_win[m] = data[5:0];
        else if (idx == CFG_TIMEOUT_TICKS) m_tmo[m] = data;
    endfunction

    // Advance one copy of the sender by one item; results land in step_res
    function automatic void advance_sender(int m, t_in_item it);
        int unsigned win, slot, stop, old_base;
        logic [31:0] calc, ackv;
        t_out_item   tail;
        step_res.delete();
        win = (m_win[m] == 0) ? 1 : ((m_win[m] > MAX_WIN) ? MAX_WIN : m_win[m]);
        if (it.req_type == REQ_MSG) begin
            if (m_next[m] - m_base[m] >= BUF_DEPTH || m_next[m] >= SEQ_CAP) begin
                tail = '0;
                tail.result_kind = KIND_REFUSE;
                step_res = {step_res, tail};
            end else begin
                slot = m_next[m] % BUF_DEPTH;
                m_lo[m][slot]   = it.pkt_word0;
                m_mid[m][slot]  = it.pkt_word1;
                m_hi[m][slot]   = it.pkt_word2;
                m_bsum[m][slot] = payload_sum(it.pkt_word0, it.pkt_word1, it.pkt_word2);
                if (m_base[m] == m_next[m] && !m_ton[m]) restart_timer(m);
                if (m_next[m] < m_base[m] + win)
                    step_res = {step_res, sent_packet(m, m_next[m])};
                m_next[m] = m_next[m] + 1;
            end
        end else if (it.req_type == REQ_ACK) begin
            ackv = it.ack_num;
            calc = it.pkt_seq + ackv + payload_sum(it.pkt_word0, it.pkt_word1, it.pkt_word2);
            if (calc == $unsigned(it.pkt_checksum) && !ackv[31] &&
                ackv >= m_base[m] && ackv < m_next[m]) begin
                old_base  = m_base[m];
                m_base[m] = ackv + 1;
                stop = (m_base[m] + win < m_next[m]) ? m_base[m] + win : m_next[m];
                for (int unsigned s = old_base + win; s < stop; s++)
                    step_res = {step_res, sent_packet(m, s)};
                restart_timer(m);
            end
        end else if (it.req_type == REQ_TICK) begin
            if (m_ton[m]) begin
                if (m_tleft[m] <= 1) begin
                    // expiry: resend the whole window
                    stop = (m_base[m] + win < m_next[m]) ? m_base[m] + win : m_next[m];
                    for (int unsigned s = m_base[m]; s < stop; s++)
                        step_res = {step_res, sent_packet(m, s)};
                    restart_timer(m);
                end else begin
                    m_tleft[m] = m_tleft[m] - 1;
                end
            end
        end
        if (step_res.size() > 0) begin
            tail = step_res.pop_back();
            tail.last = 1'b1;
            step_res = {step_res, tail};
        end
    endfunction

    function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", fname, want, got);
            n_err++;
        end
    endfunction

    // Random item with one of three payload shapes and random side fields
    function automatic t_in_item base_item(logic [1:0] req);
        t_in_item     it;
        logic [159:0] p;
        int           pick, zpos;
        for (int i = 0; i < 5; i++) p[i*32 +: 32] = $urandom;
        pick = $urandom_range(2);
        if (pick == 1) begin
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                if (p[i*8 +: 8] == 8'h00) p[i*8 +: 8] = 8'h01;
        end else if (pick == 2) begin
            zpos = $urandom_range(PAYLOAD_BYTES - 1);
            p[zpos*8 +: 8] = 8'h00;
        end
        it.req_type     = req;
        it.pkt_word0    = p[63:0];
        it.pkt_word1    = p[127:64];
        it.pkt_word2    = p[159:128];
        it.pkt_seq      = $urandom;
        it.ack_num      = $urandom;
        it.pkt_checksum = $urandom;
        return it;
    endfunction

    task automatic queue_item(t_in_item it);
        advance_sender(LOOK, it);
        req_backlog = {req_backlog, it};
        n_queued++;
    endtask

    task automatic add_fill_msg(logic [7:0] b);
        t_in_item it;
        it = base_item(REQ_MSG);
        it.pkt_word0 = {8{b}};
        it.pkt_word1 = {8{b}};
        it.pkt_word2 = {4{b}};
        queue_item(it);
    endtask

    task automatic add_ack(logic [31:0] ackv, bit corrupt);
        t_in_item it;
        it = base_item(REQ_ACK);
        it.ack_num      = ackv;
        it.pkt_checksum = it.pkt_seq + ackv +
                          payload_sum(it.pkt_word0, it.pkt_word1, it.pkt_word2);
        if (corrupt) it.pkt_checksum = it.pkt_checksum ^ (32'd1 << $urandom_range(31));
        queue_item(it);
    endtask

    // Mostly in-range acks, the rest bad checksum, negative, below base or beyond next
    task automatic add_random_ack();
        int unsigned lo, hi;
        int          pick;
        lo   = m_base[LOOK];
        hi   = m_next[LOOK];
        pick = $urandom_range(99);
        if (hi > lo && pick < 75) add_ack($urandom_range(hi - 1, lo), 1'b0);
        else if (pick < 82) add_ack(lo + $urandom_range(3), 1'b1);
        else if (pick < 88) add_ack({1'b1, 31'($urandom)}, 1'b0);
        else if (pick < 94) add_ack($urandom_range(lo - 1, 0), 1'b0);
        else add_ack(hi + $urandom_range(40), 1'b0);
    endtask

    task automatic add_msg_burst(int len);
        repeat (len) queue_item(base_item(REQ_MSG));
    endtask

    task automatic gen_random(int n, bit bursty);
        int k, r, len;
        k = 0;
        while (k < n) begin
            r = $urandom_range(99);
            if (bursty && r < 3) begin
                len = $urandom_range(38, 33);
                add_msg_burst(len);
                k += len;
            end else begin
                if (r < 45) queue_item(base_item(REQ_MSG));
                else if (r < 72) add_random_ack();
                else if (r < 97) queue_item(base_item(REQ_TICK));
                else queue_item(base_item(REQ_UNUSED));
                k++;
            end
        end
    endtask

    // Wait until every queued item is taken and every owed result has come
    task automatic settle();
        while (n_items != n_queued || due_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle();
        apply_cfg(LOOK, idx, data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // Input driver: predicts on acceptance, then offers the next backlog item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) apply_cfg(CHK, i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                advance_sender(CHK, i_in);
                if (step_res.size() > max_burst) max_burst = step_res.size();
                while (step_res.size() > 0) due_out_q = {due_out_q, step_res.pop_front()};
                n_items++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the item until taken
            end else if (req_backlog.size() > 0 && !(idle_on && $urandom_range(99) < 20)) begin
                i_in       <= req_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready: random gaps, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
            stalls_done <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (stalls_done != stalls_asked) begin
            i_out_ready <= 1'b0;
            stall_left  <= LONG_STALL;
            stalls_done <= stalls_done + 1;
        end else begin
            i_out_ready <= !(idle_on && $urandom_range(99) < 20);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_out_q.size() == 0) begin
                $error("result item with nothing owed: kind %0d seq %0d",
                       o_out.result_kind, o_out.out_seq);
                n_err++;
            end else begin
                got_want = due_out_q.pop_front();
                check_field("result_kind", got_want.result_kind, o_out.result_kind);
                check_field("out_seq", got_want.out_seq, o_out.out_seq);
                check_field("out_word0", got_want.out_word0, o_out.out_word0);
                check_field("out_word1", got_want.out_word1, o_out.out_word1);
                check_field("out_word2", got_want.out_word2, o_out.out_word2);
                check_field("out_checksum", got_want.out_checksum, o_out.out_checksum);
                check_field("last", got_want.last, o_out.last);
                if (got_want.result_kind == KIND_REFUSE) n_refused++;
                n_results++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $error("run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        for (int m = 0; m < 2; m++) begin
            m_base[m]  = 1;
            m_next[m]  = 1;
            m_tleft[m] = 0;
            m_ton[m]   = 1'b0;
            m_win[m]   = 6'd8;
            m_tmo[m]   = 16'd14;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: idle tick, unused code, payload extremes, window edge
        queue_item(base_item(REQ_TICK));
        queue_item(base_item(REQ_UNUSED));
        add_fill_msg(8'h00);
        add_fill_msg(8'hFF);
        add_fill_msg(8'h80);
        add_fill_msg(8'h7F);
        add_msg_burst(5);                       // last one falls outside the window
        add_ack(m_base[LOOK], 1'b1);            // bad checksum
        add_ack(32'h8000_0001, 1'b0);           // negative ack number
        add_ack(m_next[LOOK], 1'b0);            // not yet sent
        add_ack(32'd0, 1'b0);                   // below base
        add_ack(m_base[LOOK], 1'b0);            // good: slides window by one
        queue_item(base_item(REQ_MSG));

        // Directed, zero window and zero timeout: all acked, start while running, expiry
        write_reg(CFG_TIMEOUT_TICKS, 16'd0);
        write_reg(CFG_WINDOW_SIZE, 16'd0);
        add_ack(m_next[LOOK] - 1, 1'b0);
        queue_item(base_item(REQ_TICK));
        queue_item(base_item(REQ_MSG));
        queue_item(base_item(REQ_TICK));
        queue_item(base_item(REQ_MSG));
        queue_item(base_item(REQ_TICK));

        // Random phases over several settings
        write_reg(CFG_WINDOW_SIZE, 16'd8);
        write_reg(CFG_TIMEOUT_TICKS, 16'd14);
        settle();
        stalls_asked++;                         // output held off while inputs keep coming
        gen_random(70, 1'b0);

        write_reg(CFG_WINDOW_SIZE, 16'd1);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        gen_random(60, 1'b0);

        write_reg(CFG_WINDOW_SIZE, 16'd32);
        write_reg(CFG_TIMEOUT_TICKS, 16'd5);
        add_msg_burst(36);                      // fills the buffer, then refusals
        gen_random(40, 1'b1);

        write_reg(CFG_WINDOW_SIZE, 16'hFFFF);   // window 63 acts as 32
        write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        idle_on = 1'b0;
        gen_random(60, 1'b0);
        settle();
        idle_on = 1'b1;

        write_reg(CFG_WINDOW_SIZE, 16'hAB04);   // upper data bits ignored
        write_reg(CFG_TIMEOUT_TICKS, 16'd3);
        gen_random(30, 1'b0);
        settle();                               // stimulus pauses until all results are in
        gen_random(30, 1'b0);

        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_WINDOW_SIZE, 16'd16);
        write_reg(CFG_TIMEOUT_TICKS, 16'd2);
        gen_random(65, 1'b1);

        write_reg(CFG_WINDOW_SIZE, 16'd5);
        write_reg(CFG_TIMEOUT_TICKS, 16'd0);
        gen_random(65, 1'b0);

        settle();
        $display("Sent %0d input items, checked %0d result items (%0d refusals).",
                 n_items, n_results, n_refused);
        $display("Register writes: %0d; largest burst from one item: %0d packets.",
                 n_cfg, max_burst);
        if (n_err == 0 && due_out_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
